### rtl/adpcm_byte_stream_decoder_defines.svh
// Assertion macros shared by the decoder's checker.
// Needs nothing else; include by bare file name.
`ifndef ADPCM_BYTE_STREAM_DECODER_DEFINES_SVH
`define ADPCM_BYTE_STREAM_DECODER_DEFINES_SVH

// Same-cycle implication, checks off while reset is held.
`define ABD_ASSERT_IMP(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("abd: same-cycle check failed");

// Next-cycle implication, checks off while reset is held.
`define ABD_ASSERT_NXT(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("abd: next-cycle check failed");

`endif

### rtl/abd_pkg.sv
// Types, constants and lookup tables for the ADPCM byte-stream decoder.
// No dependencies; the front end, queue, back end and top level use it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package abd_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [1:0] CH_STEREO   = 2'd2;
  localparam logic [1:0] CFG_RESET   = 2'd1;

  localparam logic [6:0] STEP_MAX    = 7'd88;
  localparam logic [6:0] STEP_INIT   = 7'd44;
  localparam logic [6:0] STEP_JUMP   = 7'd8;

  localparam logic [15:0] SAMPLE_MAX = 16'h7FFF;
  localparam logic [15:0] SAMPLE_MIN = 16'h8000;

  localparam logic [6:0] CODE_REPEAT  = 7'h00;
  localparam logic [6:0] CODE_STEP_UP = 7'h01;

  typedef enum logic [2:0] {
    PH_SKIP,
    PH_SHIFT,
    PH_LO0,
    PH_HI0,
    PH_LO1,
    PH_HI1,
    PH_DECODE
  } phase_e;

  typedef enum logic [2:0] {
    OP_START,
    OP_INIT,
    OP_REPEAT,
    OP_STEP_UP,
    OP_STEP_DOWN,
    OP_DELTA
  } op_e;

  // One queued work item for the back end.
  typedef struct packed {
    op_e         op;
    logic        ch;
    logic [15:0] data;        // initial sample, or the code byte in [7:0]
    logic        shift_zero;  // shift of 16 or more: base term is zero
    logic [3:0]  shift;
  } op_t;

  localparam logic [14:0] STEP_TAB [89] = '{
    15'h0007, 15'h0008, 15'h0009, 15'h000A, 15'h000B, 15'h000C, 15'h000D, 15'h000E,
    15'h0010, 15'h0011, 15'h0013, 15'h0015, 15'h0017, 15'h0019, 15'h001C, 15'h001F,
    15'h0022, 15'h0025, 15'h0029, 15'h002D, 15'h0032, 15'h0037, 15'h003C, 15'h0042,
    15'h0049, 15'h0050, 15'h0058, 15'h0061, 15'h006B, 15'h0076, 15'h0082, 15'h008F,
    15'h009D, 15'h00AD, 15'h00BE, 15'h00D1, 15'h00E6, 15'h00FD, 15'h0117, 15'h0133,
    15'h0151, 15'h0173, 15'h0198, 15'h01C1, 15'h01EE, 15'h0220, 15'h0256, 15'h0292,
    15'h02D4, 15'h031C, 15'h036C, 15'h03C3, 15'h0424, 15'h048E, 15'h0502, 15'h0583,
    15'h0610, 15'h06AB, 15'h0756, 15'h0812, 15'h08E0, 15'h09C3, 15'h0ABD, 15'h0BD0,
    15'h0CFF, 15'h0E4C, 15'h0FBA, 15'h114C, 15'h1307, 15'h14EE, 15'h1706, 15'h1954,
    15'h1BDC, 15'h1EA5, 15'h21B6, 15'h2515, 15'h28CA, 15'h2CDF, 15'h315B, 15'h364B,
    15'h3BB9, 15'h41B2, 15'h4844, 15'h4F7E, 15'h5771, 15'h602F, 15'h69CE, 15'h7462,
    15'h7FFF
  };

  localparam logic signed [4:0] IDX_ADJ [32] = '{
    -5'sd1, 5'sd0, -5'sd1, 5'sd4, -5'sd1, 5'sd2, -5'sd1, 5'sd6,
    -5'sd1, 5'sd1, -5'sd1, 5'sd5, -5'sd1, 5'sd3, -5'sd1, 5'sd7,
    -5'sd1, 5'sd1, -5'sd1, 5'sd5, -5'sd1, 5'sd3, -5'sd1, 5'sd7,
    -5'sd1, 5'sd2, -5'sd1, 5'sd4, -5'sd1, 5'sd6, -5'sd1, 5'sd8
  };

  function automatic logic [14:0] step_lookup(logic [6:0] idx);
    logic [6:0] safe;
    safe = (idx > STEP_MAX) ? STEP_MAX : idx;
    return STEP_TAB[safe];
  endfunction

  function automatic logic signed [4:0] idx_adjust(logic [4:0] code);
    return IDX_ADJ[code];
  endfunction

endpackage

`default_nettype wire

### rtl/abd_stream_if.sv
// Valid/ready channel interfaces: compressed bytes in, PCM samples out.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface abd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       stream_start;

  modport source (output valid, output in_byte, output stream_start, input ready);
  modport sink   (input valid, input in_byte, input stream_start, output ready);
endinterface

interface abd_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample;
  logic               channel_id;

  modport source (output valid, output sample, output channel_id, input ready);
  modport sink   (input valid, input sample, input channel_id, output ready);
endinterface

`default_nettype wire

### rtl/abd_front.sv
// Front end: walks the block header, tracks the channel, classifies bytes
// into work items for the back end. Uses abd_pkg and abd_in_if.
`timescale 1ns / 1ps
`default_nettype none

module abd_front (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         stereo_i,
  abd_in_if.sink            in_i,
  input  wire logic         full_i,
  output abd_pkg::op_t      op_o,
  output logic              push_o
);

  abd_pkg::phase_e phase_q, phase_d;
  logic       shift_zero_q, shift_zero_d;
  logic [3:0] shift_q, shift_d;
  logic [7:0] low_q, low_d;
  logic       cur_q, cur_d;
  logic       acc;
  logic       dec_ch;
  logic [6:0] code;

  assign in_i.ready = !full_i;
  assign acc        = in_i.valid && in_i.ready;
  assign dec_ch     = stereo_i ? ~cur_q : cur_q;
  assign code       = in_i.in_byte[6:0];

  always_comb begin
    phase_d = phase_q;
    if (acc) begin
      if (in_i.stream_start) begin
        phase_d = abd_pkg::PH_SHIFT;
      end else begin
        case (phase_q)
          abd_pkg::PH_SKIP:   phase_d = abd_pkg::PH_SHIFT;
          abd_pkg::PH_SHIFT:  phase_d = abd_pkg::PH_LO0;
          abd_pkg::PH_LO0:    phase_d = abd_pkg::PH_HI0;
          abd_pkg::PH_HI0:    phase_d = stereo_i ? abd_pkg::PH_LO1 : abd_pkg::PH_DECODE;
          abd_pkg::PH_LO1:    phase_d = abd_pkg::PH_HI1;
          abd_pkg::PH_HI1:    phase_d = abd_pkg::PH_DECODE;
          abd_pkg::PH_DECODE: phase_d = abd_pkg::PH_DECODE;
          default:            phase_d = abd_pkg::PH_SKIP;
        endcase
      end
    end
  end

  always_comb begin
    push_o          = 1'b0;
    op_o.op         = abd_pkg::OP_DELTA;
    op_o.ch         = dec_ch;
    op_o.data       = {8'h00, in_i.in_byte};
    op_o.shift_zero = shift_zero_q;
    op_o.shift      = shift_q;
    shift_zero_d    = shift_zero_q;
    shift_d         = shift_q;
    low_d           = low_q;
    cur_d           = cur_q;
    if (acc) begin
      if (in_i.stream_start) begin
        push_o  = 1'b1;
        op_o.op = abd_pkg::OP_START;
        cur_d   = stereo_i;
      end else begin
        case (phase_q)
          abd_pkg::PH_SHIFT: begin
            shift_zero_d = |in_i.in_byte[7:4];
            shift_d      = in_i.in_byte[3:0];
          end
          abd_pkg::PH_LO0, abd_pkg::PH_LO1: begin
            low_d = in_i.in_byte;
          end
          abd_pkg::PH_HI0, abd_pkg::PH_HI1: begin
            push_o    = 1'b1;
            op_o.op   = abd_pkg::OP_INIT;
            op_o.ch   = (phase_q == abd_pkg::PH_HI1);
            op_o.data = {in_i.in_byte, low_q};
          end
          abd_pkg::PH_DECODE: begin
            push_o = 1'b1;
            cur_d  = dec_ch;
            if (in_i.in_byte[7]) begin
              if (code == abd_pkg::CODE_REPEAT) begin
                op_o.op = abd_pkg::OP_REPEAT;
              end else begin
                op_o.op = (code == abd_pkg::CODE_STEP_UP) ? abd_pkg::OP_STEP_UP
                                                          : abd_pkg::OP_STEP_DOWN;
                // stereo: a step control does not advance the channel
                cur_d   = cur_q;
              end
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= abd_pkg::PH_SKIP;
      cur_q   <= 1'b0;
    end else begin
      phase_q <= phase_d;
      cur_q   <= cur_d;
    end
  end

  // reset values for these do not matter: each is written before first use
  always_ff @(posedge clk_i) begin
    shift_zero_q <= shift_zero_d;
    shift_q      <= shift_d;
    low_q        <= low_d;
  end

endmodule

`default_nettype wire

### rtl/abd_op_queue.sv
// Short FIFO of work items between the front and back ends.
// Uses abd_pkg for the item type and depth.
`timescale 1ns / 1ps
`default_nettype none

module abd_op_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  abd_pkg::op_t       push_op_i,
  output logic               full_o,
  output logic               head_valid_o,
  output abd_pkg::op_t       head_o,
  input  wire logic          pop_i
);

  localparam int unsigned PtrW = abd_pkg::QUEUE_PTR_W;
  localparam int unsigned CntW = abd_pkg::QUEUE_CNT_W;
  localparam logic [PtrW-1:0] PtrLast = PtrW'(abd_pkg::QUEUE_DEPTH - 1);

  abd_pkg::op_t    mem_q [abd_pkg::QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o       = (cnt_q == CntW'(abd_pkg::QUEUE_DEPTH));
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_op_i;
    end
  end

endmodule

`default_nettype wire

### rtl/abd_back.sv
// Back end: holds step indexes and predictors, decodes one work item per
// cycle, unless the registered output stalls. Uses abd_pkg and abd_out_if.
`timescale 1ns / 1ps
`default_nettype none

module abd_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          head_valid_i,
  input  abd_pkg::op_t       head_i,
  output logic               pop_o,
  abd_out_if.source          out_o
);

  logic [6:0]         step_idx_q [2];
  logic [6:0]         step_idx_d [2];
  logic signed [15:0] pred_q [2];
  logic signed [15:0] pred_d [2];
  logic               out_valid_q, out_valid_d;
  logic signed [15:0] sample_q, sample_d;
  logic               chan_q, chan_d;

  logic               ch;
  logic [7:0]         b;
  logic [6:0]         idx;
  logic [14:0]        step;
  logic [14:0]        base;
  logic [16:0]        delta;
  logic signed [17:0] sum;
  logic signed [15:0] sat;
  logic signed [8:0]  idx_sum;
  logic [6:0]         idx_adapt;
  logic [6:0]         idx_up;
  logic [6:0]         idx_down;
  logic [6:0]         idx_dec;
  logic               emits;
  logic               emit;

  assign ch   = head_i.ch;
  assign b    = head_i.data[7:0];
  assign idx  = step_idx_q[ch];
  assign step = abd_pkg::step_lookup(idx);
  assign base = head_i.shift_zero ? '0 : (step >> head_i.shift);

  always_comb begin
    delta = {2'b00, base};
    for (int k = 0; k < 6; k++) begin
      if (b[k]) begin
        delta = delta + 17'(step >> k);
      end
    end
  end

  // 18 bits hold predictor +/- delta without wrap
  assign sum = b[6] ? ({{2{pred_q[ch][15]}}, pred_q[ch]} - $signed({1'b0, delta}))
                    : ({{2{pred_q[ch][15]}}, pred_q[ch]} + $signed({1'b0, delta}));
  assign sat = (sum[17:15] == {3{sum[17]}}) ? sum[15:0]
             : (sum[17] ? abd_pkg::SAMPLE_MIN : abd_pkg::SAMPLE_MAX);

  assign idx_sum   = $signed({2'b00, idx}) + 9'(abd_pkg::idx_adjust(b[4:0]));
  assign idx_adapt = idx_sum[8] ? '0
                   : ((idx_sum > $signed({2'b00, abd_pkg::STEP_MAX})) ? abd_pkg::STEP_MAX
                                                                       : idx_sum[6:0]);
  assign idx_up    = (idx > abd_pkg::STEP_MAX - abd_pkg::STEP_JUMP) ? abd_pkg::STEP_MAX
                                                                    : idx + abd_pkg::STEP_JUMP;
  assign idx_down  = (idx < abd_pkg::STEP_JUMP) ? '0 : idx - abd_pkg::STEP_JUMP;
  assign idx_dec   = (idx == '0) ? '0 : idx - 1'b1;

  assign emits = (head_i.op == abd_pkg::OP_INIT) || (head_i.op == abd_pkg::OP_REPEAT)
              || (head_i.op == abd_pkg::OP_DELTA);
  assign pop_o = head_valid_i && (!emits || !out_valid_q || out_o.ready);
  assign emit  = pop_o && emits;

  always_comb begin
    step_idx_d = step_idx_q;
    pred_d     = pred_q;
    sample_d   = sample_q;
    chan_d     = chan_q;
    if (pop_o) begin
      case (head_i.op)
        abd_pkg::OP_START: begin
          step_idx_d[0] = abd_pkg::STEP_INIT;
          step_idx_d[1] = abd_pkg::STEP_INIT;
          pred_d[0]     = '0;
          pred_d[1]     = '0;
        end
        abd_pkg::OP_INIT: begin
          pred_d[ch] = head_i.data;
          sample_d   = head_i.data;
          chan_d     = ch;
        end
        abd_pkg::OP_REPEAT: begin
          step_idx_d[ch] = idx_dec;
          sample_d       = pred_q[ch];
          chan_d         = ch;
        end
        abd_pkg::OP_STEP_UP: begin
          step_idx_d[ch] = idx_up;
        end
        abd_pkg::OP_STEP_DOWN: begin
          step_idx_d[ch] = idx_down;
        end
        abd_pkg::OP_DELTA: begin
          step_idx_d[ch] = idx_adapt;
          pred_d[ch]     = sat;
          sample_d       = sat;
          chan_d         = ch;
        end
        default: begin
        end
      endcase
    end
  end

  assign out_valid_d = emit ? 1'b1 : (out_o.ready ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_idx_q[0] <= abd_pkg::STEP_INIT;
      step_idx_q[1] <= abd_pkg::STEP_INIT;
      pred_q[0]     <= '0;
      pred_q[1]     <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      step_idx_q  <= step_idx_d;
      pred_q      <= pred_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sample_q <= sample_d;
    chan_q   <= chan_d;
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.sample     = sample_q;
  assign out_o.channel_id = chan_q;

endmodule

`default_nettype wire

### rtl/adpcm_byte_stream_decoder.sv
// ADPCM byte-stream decoder, top level: front end, work queue, back end.
// A byte's sample goes via the work queue and the output register to out_o.
// Throughput: one byte per cycle, held by the back end's combinational
// step lookup, shift-add and clamp path; the queue absorbs stalls until full.
// Reset (async, active low): header parse restarts, mono, step indexes 44,
// predictors 0, queue and output empty; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module adpcm_byte_stream_decoder (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [1:0] cfg_wdata_i,
  abd_in_if.sink          in_i,
  abd_out_if.source       out_o
);

  logic [1:0]   channels_q;
  logic         stereo;
  logic         push;
  logic         full;
  logic         head_valid;
  logic         pop;
  abd_pkg::op_t push_op;
  abd_pkg::op_t head_op;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      channels_q <= abd_pkg::CFG_RESET;
    end else if (cfg_we_i) begin
      channels_q <= cfg_wdata_i;
    end
  end

  assign stereo = (channels_q == abd_pkg::CH_STEREO);

  abd_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .stereo_i (stereo),
    .in_i     (in_i),
    .full_i   (full),
    .op_o     (push_op),
    .push_o   (push)
  );

  abd_op_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_op_i    (push_op),
    .full_o       (full),
    .head_valid_o (head_valid),
    .head_o       (head_op),
    .pop_i        (pop)
  );

  abd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head_op),
    .pop_o        (pop),
    .out_o        (out_o)
  );

endmodule

`default_nettype wire

### rtl/abd_checker.sv
// Port-level checks for the decoder, bound to the top level.
// Depends on adpcm_byte_stream_decoder_defines.svh for the assertion macros.
`timescale 1ns / 1ps
`default_nettype none

`include "adpcm_byte_stream_decoder_defines.svh"

module abd_port_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_ready_i,
  input wire logic               out_valid_i,
  input wire logic               out_ready_i,
  input wire logic signed [15:0] sample_i,
  input wire logic               channel_id_i
);

  logic in_xfer;

  assign in_xfer = in_valid_i && in_ready_i;

  // a stalled result keeps its payload
  `ABD_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(sample_i) && $stable(channel_id_i))

  // with the sink taking everything the queue never fills
  `ABD_ASSERT_IMP(a_in_ready_free, clk_i, rst_ni, $past(out_ready_i), in_ready_i)

  // with no input and the sink ready, the queue and output register drain
  `ABD_ASSERT_IMP(a_drain, clk_i, rst_ni, !$past(in_xfer) && !$past(in_xfer, 2) && !$past(in_xfer, 3) && $past(out_ready_i) && $past(out_ready_i, 2) && $past(out_ready_i, 3), !out_valid_i)

endmodule

bind adpcm_byte_stream_decoder abd_port_checker u_abd_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .sample_i     (out_o.sample),
  .channel_id_i (out_o.channel_id)
);

`default_nettype wire
